### src/gncs_pkg.sv
// ----------------------------------------------------------------------------
// gncs_pkg
// Widths, constants, types and helper functions shared by the nearest-corner
// selector and its channel interfaces.
// ----------------------------------------------------------------------------
package gncs_pkg;

    localparam int FRAC_BITS = 16;            // fraction bits of weights
    localparam int LAT_W     = 28;            // latitude field width
    localparam int LON_W     = 31;            // longitude field width
    localparam int VAL_W     = 64;            // corner value width
    localparam int TOL_W     = 16;            // tie tolerance width
    localparam int NUM_W     = 31;            // dividend magnitude width
    localparam int NB        = NUM_W + FRAC_BITS; // quotient bits = divider stages
    localparam int DW        = 32;            // divisor and remainder width
    localparam int WW        = FRAC_BITS + 3; // signed latitude weight width
    localparam int FW        = FRAC_BITS + 2; // signed longitude fraction width
    localparam int MW        = FRAC_BITS + 2; // magnitude width before squaring
    localparam int SQW       = 2 * MW;        // square width
    localparam int DSW       = SQW + 1;       // squared distance width
    localparam int CMW       = DSW + 1;       // compare width (distance + tolerance)

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam logic [1:0] CORNER_NW = 2'd0;
    localparam logic [1:0] CORNER_NE = 2'd1;
    localparam logic [1:0] CORNER_SW = 2'd2;
    localparam logic [1:0] CORNER_SE = 2'd3;

    localparam logic [NB-1:0] ONE_Q  = NB'(1) << FRAC_BITS;
    localparam logic [NB-1:0] TWO_Q  = NB'(2) << FRAC_BITS;
    localparam logic [WW-1:0] ONE_WW = WW'(1) << FRAC_BITS;
    localparam logic [WW-1:0] TWO_WW = WW'(2) << FRAC_BITS;
    localparam logic [FW-1:0] ONE_FW = FW'(1) << FRAC_BITS;

    // One restoring-division stage: dividend bits shift out of the top of
    // qn while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [NB-1:0] qn;
        logic [DW-1:0] rem;
        logic [DW-1:0] den;
    } t_div;

    typedef struct packed {
        logic                  zero;
        logic [3:0][VAL_W-1:0] values;
    } t_carry;

    typedef struct packed {
        t_div   lat;
        t_div   lonn;
        t_div   lons;
        logic   lat_neg;
        logic   lon_neg;
        t_carry c;
    } t_div_st;

    function automatic t_div div_step(input t_div d);
        logic [DW:0] trial;
        t_div        r;
        trial  = {d.rem, d.qn[NB-1]};
        r.den  = d.den;
        if (trial >= {1'b0, d.den}) begin
            r.rem = DW'(trial - {1'b0, d.den});
            r.qn  = {d.qn[NB-2:0], 1'b1};
        end else begin
            r.rem = trial[DW-1:0];
            r.qn  = {d.qn[NB-2:0], 1'b0};
        end
        return r;
    endfunction

    // Signed longitude fraction from an unsigned quotient magnitude and sign.
    function automatic logic [FW-1:0] lon_frac(input logic [NB-1:0] qm, input logic neg);
        logic [FW-1:0] low;
        logic [FW-1:0] r;
        low = FW'(qm[FRAC_BITS-1:0]);
        if (!neg) begin
            r = low;
        end else if (qm <= ONE_Q) begin
            r = FW'(FRAC_BITS'(0 - qm[FRAC_BITS-1:0]));
        end else begin
            r = FW'(0) - low;
        end
        return r;
    endfunction

endpackage

### src/gncs_in_if.sv
// ----------------------------------------------------------------------------
// gncs_in_if
// Input channel of the nearest-corner selector: one target point and its cell.
// ----------------------------------------------------------------------------
interface gncs_in_if
    import gncs_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] target_lat;
    logic signed [LON_W-1:0] target_lon;
    logic signed [LAT_W-1:0] north_row_lat;
    logic signed [LAT_W-1:0] south_row_lat;
    logic signed [LON_W-1:0] nw_lon;
    logic signed [LON_W-1:0] ne_lon;
    logic signed [LON_W-1:0] sw_lon;
    logic signed [LON_W-1:0] se_lon;
    logic [VAL_W-1:0]        nw_value;
    logic [VAL_W-1:0]        ne_value;
    logic [VAL_W-1:0]        sw_value;
    logic [VAL_W-1:0]        se_value;

    modport source (output valid, target_lat, target_lon, north_row_lat, south_row_lat,
                    nw_lon, ne_lon, sw_lon, se_lon, nw_value, ne_value, sw_value,
                    se_value, input ready);
    modport sink   (input valid, target_lat, target_lon, north_row_lat, south_row_lat,
                    nw_lon, ne_lon, sw_lon, se_lon, nw_value, ne_value, sw_value,
                    se_value, output ready);
endinterface

### src/gncs_out_if.sv
// ----------------------------------------------------------------------------
// gncs_out_if
// Result channel of the nearest-corner selector.
// ----------------------------------------------------------------------------
interface gncs_out_if
    import gncs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] chosen_value;
    logic [1:0]       chosen_corner;
    logic             zero_divisor;

    modport source (output valid, chosen_value, chosen_corner, zero_divisor, input ready);
    modport sink   (input valid, chosen_value, chosen_corner, zero_divisor, output ready);
endinterface

### src/grid_nearest_corner_select.sv
// ----------------------------------------------------------------------------
// grid_nearest_corner_select
// Picks the value of the grid corner nearest to a target point.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled and
// delivers one result per item, in order, through these register stages:
// one entry stage, one stage per quotient bit of three parallel restoring
// dividers (latitude weight and the two row fractions), then stages for the
// weight fixups, the squares, the distance sums and the final compare and
// select into the output register. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stall at the
// output freezes every stage and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module grid_nearest_corner_select
    import gncs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    gncs_in_if.sink          i_in,
    gncs_out_if.source       o_res
);

    // Tie tolerance register. The user must write it only while the pipeline is empty; the block does not check.
    logic [TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Global advance: every stage moves when the output register can accept.
    logic r_out_valid;
    logic adv;
    assign adv        = !r_out_valid || o_res.ready;
    assign i_in.ready = adv;

    // Entry stage: differences, magnitudes, signs and the zero-divisor test.
    logic [LAT_W:0]   span, latnum;
    logic [LAT_W:0]   span_mag, latnum_mag;
    logic [DW-1:0]    dn, ds, dn_mag, ds_mag;
    logic [NUM_W-1:0] tlon_mag;
    t_div_st          n_entry;

    always_comb begin
        span       = {i_in.north_row_lat[LAT_W-1], i_in.north_row_lat}
                   - {i_in.south_row_lat[LAT_W-1], i_in.south_row_lat};
        latnum     = {i_in.north_row_lat[LAT_W-1], i_in.north_row_lat}
                   - {i_in.target_lat[LAT_W-1], i_in.target_lat};
        span_mag   = span[LAT_W] ? (LAT_W+1)'(0) - span : span;
        latnum_mag = latnum[LAT_W] ? (LAT_W+1)'(0) - latnum : latnum;
        dn         = DW'(signed'(i_in.ne_lon)) - DW'(signed'(i_in.nw_lon));
        ds         = DW'(signed'(i_in.se_lon)) - DW'(signed'(i_in.sw_lon));
        dn_mag     = dn[DW-1] ? DW'(0) - dn : dn;
        ds_mag     = ds[DW-1] ? DW'(0) - ds : ds;
        tlon_mag   = i_in.target_lon[LON_W-1] ? NUM_W'(0) - NUM_W'(i_in.target_lon)
                                             : NUM_W'(i_in.target_lon);

        n_entry.lat.qn   = {NUM_W'(latnum_mag), {FRAC_BITS{1'b0}}};
        n_entry.lat.rem  = '0;
        n_entry.lat.den  = DW'(span_mag);
        n_entry.lonn.qn  = {tlon_mag, {FRAC_BITS{1'b0}}};
        n_entry.lonn.rem = '0;
        n_entry.lonn.den = dn_mag;
        n_entry.lons.qn  = {tlon_mag, {FRAC_BITS{1'b0}}};
        n_entry.lons.rem = '0;
        n_entry.lons.den = ds_mag;
        n_entry.lat_neg  = latnum[LAT_W] ^ span[LAT_W];
        n_entry.lon_neg  = i_in.target_lon[LON_W-1];
        n_entry.c.zero   = (span_mag == '0) || (dn_mag == '0) || (ds_mag == '0);
        n_entry.c.values = {i_in.se_value, i_in.sw_value, i_in.ne_value, i_in.nw_value};
    end

    // Divider pipeline: stage 0 is the entry register, stage k holds k
    // quotient bits. A zero divisor runs through harmlessly and is masked.
    logic    r_dv_valid [0:NB];
    t_div_st r_dv       [0:NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (adv) begin
            r_dv_valid[0] <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0] <= n_entry;
        end
    end

    for (genvar k = 1; k <= NB; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k] <= 1'b0;
            end else if (adv) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[k].lat     <= div_step(r_dv[k-1].lat);
                r_dv[k].lonn    <= div_step(r_dv[k-1].lonn);
                r_dv[k].lons    <= div_step(r_dv[k-1].lons);
                r_dv[k].lat_neg <= r_dv[k-1].lat_neg;
                r_dv[k].lon_neg <= r_dv[k-1].lon_neg;
                r_dv[k].c       <= r_dv[k-1].c;
            end
        end
    end

    // Fixup stage: signed, saturated latitude weights and row fractions.
    logic [NB-1:0] lat_q;
    logic [WW-1:0] n_w1;
    logic [FW-1:0] n_fwn, n_fws;

    always_comb begin
        lat_q = r_dv[NB].lat.qn;
        if (r_dv[NB].lat_neg) begin
            n_w1 = (lat_q > ONE_Q) ? WW'(0) - ONE_WW : WW'(0) - lat_q[WW-1:0];
        end else begin
            n_w1 = (lat_q > TWO_Q) ? TWO_WW : lat_q[WW-1:0];
        end
        n_fwn = lon_frac(r_dv[NB].lonn.qn, r_dv[NB].lon_neg);
        n_fws = lon_frac(r_dv[NB].lons.qn, r_dv[NB].lon_neg);
    end

    logic          r_p1_valid;
    logic [WW-1:0] r_w1, r_w2;
    logic [FW-1:0] r_fwn, r_fen, r_fws, r_fes;
    t_carry        r_p1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= r_dv_valid[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w1   <= n_w1;
            r_w2   <= ONE_WW - n_w1;
            r_fwn  <= n_fwn;
            r_fen  <= ONE_FW - n_fwn;
            r_fws  <= n_fws;
            r_fes  <= ONE_FW - n_fws;
            r_p1_c <= r_dv[NB].c;
        end
    end

    // Square stage: six independent narrow multiplies on magnitudes.
    logic [MW-1:0] m_w1, m_w2, m_fwn, m_fen, m_fws, m_fes;

    always_comb begin
        m_w1  = MW'(r_w1[WW-1]  ? WW'(0) - r_w1  : r_w1);
        m_w2  = MW'(r_w2[WW-1]  ? WW'(0) - r_w2  : r_w2);
        m_fwn = MW'(r_fwn[FW-1] ? FW'(0) - r_fwn : r_fwn);
        m_fen = MW'(r_fen[FW-1] ? FW'(0) - r_fen : r_fen);
        m_fws = MW'(r_fws[FW-1] ? FW'(0) - r_fws : r_fws);
        m_fes = MW'(r_fes[FW-1] ? FW'(0) - r_fes : r_fes);
    end

    logic           r_p2_valid;
    logic [SQW-1:0] r_sw1, r_sw2, r_sfwn, r_sfen, r_sfws, r_sfes;
    t_carry         r_p2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sw1  <= SQW'(m_w1)  * SQW'(m_w1);
            r_sw2  <= SQW'(m_w2)  * SQW'(m_w2);
            r_sfwn <= SQW'(m_fwn) * SQW'(m_fwn);
            r_sfen <= SQW'(m_fen) * SQW'(m_fen);
            r_sfws <= SQW'(m_fws) * SQW'(m_fws);
            r_sfes <= SQW'(m_fes) * SQW'(m_fes);
            r_p2_c <= r_p1_c;
        end
    end

    // Distance stage: four squared distances.
    logic           r_p3_valid;
    logic [DSW-1:0] r_dnw, r_dne, r_dsw, r_dse;
    t_carry         r_p3_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dnw  <= DSW'(r_sfwn) + DSW'(r_sw1);
            r_dne  <= DSW'(r_sfen) + DSW'(r_sw1);
            r_dsw  <= DSW'(r_sfws) + DSW'(r_sw2);
            r_dse  <= DSW'(r_sfes) + DSW'(r_sw2);
            r_p3_c <= r_p2_c;
        end
    end

    // Select stage: "a before b" means a is no more than b plus the
    // tolerance; earlier corners win ties.
    logic [CMW-1:0] t_ne, t_sw, t_se;
    logic           nw_ne, nw_sw, nw_se, ne_sw, ne_se, sw_se;
    logic [1:0]     n_corner;

    always_comb begin
        t_ne  = CMW'(r_dne) + CMW'(r_tol);
        t_sw  = CMW'(r_dsw) + CMW'(r_tol);
        t_se  = CMW'(r_dse) + CMW'(r_tol);
        nw_ne = CMW'(r_dnw) <= t_ne;
        nw_sw = CMW'(r_dnw) <= t_sw;
        nw_se = CMW'(r_dnw) <= t_se;
        ne_sw = CMW'(r_dne) <= t_sw;
        ne_se = CMW'(r_dne) <= t_se;
        sw_se = CMW'(r_dsw) <= t_se;
        if (r_p3_c.zero || (nw_ne && nw_sw && nw_se)) begin
            n_corner = CORNER_NW;
        end else if (ne_sw && ne_se) begin
            n_corner = CORNER_NE;
        end else if (sw_se) begin
            n_corner = CORNER_SW;
        end else begin
            n_corner = CORNER_SE;
        end
    end

    logic [VAL_W-1:0] r_out_value;
    logic [1:0]       r_out_corner;
    logic             r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_value  <= r_p3_c.values[n_corner];
            r_out_corner <= n_corner;
            r_out_zero   <= r_p3_c.zero;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.chosen_value  = r_out_value;
    assign o_res.chosen_corner = r_out_corner;
    assign o_res.zero_divisor  = r_out_zero;

endmodule

### verif/grid_nearest_corner_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_nearest_corner_select_tb
// Self-checking bench for the nearest-corner selector. It drives target points
// with random idling on both channels, predicts the chosen corner of each item
// in fixed point and compares every result in order.
// ----------------------------------------------------------------------------
module grid_nearest_corner_select_tb;
    import gncs_pkg::*;

    // Expected result of one item.
    typedef struct {
        logic [VAL_W-1:0] value;
        logic [1:0]       corner;
        logic             zero;
    } t_pick;

    // One input item, kept as plain fields so that tasks can build it.
    typedef struct {
        logic signed [LAT_W-1:0] tlat, nlat, slat;
        logic signed [LON_W-1:0] tlon, lnw, lne, lsw, lse;
        logic [VAL_W-1:0]        v [4];
    } t_point;

    // The scoreboard holds the tolerance in force and the queue of picks that
    // the block still owes.
    class corner_board;
        t_pick            owed[$];
        logic [TOL_W-1:0] tol;
        int               errors;

        function new();
            tol    = TOL_RESET;
            errors = 0;
        endfunction

        // Signed (num * ONE) / den with truncation toward zero.
        function longint frac_div(longint num, longint den);
            longint qm;
            qm = ((num < 0 ? -num : num) <<< FRAC_BITS) / (den < 0 ? -den : den);
            return ((num < 0) != (den < 0)) ? -qm : qm;
        endfunction

        // The row spacing is a magnitude, so only the longitude sets the sign.
        function longint row_frac(longint lon, longint spacing);
            longint q;
            longint fm;
            q  = frac_div(lon, spacing < 0 ? -spacing : spacing)
               + (longint'(1) <<< FRAC_BITS);
            fm = (q < 0 ? -q : q) & ((longint'(1) <<< FRAC_BITS) - 1);
            return q < 0 ? -fm : fm;
        endfunction

        function bit ahead(longint a, longint b);
            return a <= b + longint'(tol);
        endfunction

        function void note_point(t_point p);
            longint one, span, sn, ss, w1, w2, fwn, fws;
            longint d[4];
            t_pick  e;
            one  = longint'(1) <<< FRAC_BITS;
            span = longint'(p.nlat) - longint'(p.slat);
            sn   = longint'(p.lne) - longint'(p.lnw);
            ss   = longint'(p.lse) - longint'(p.lsw);
            if (span == 0 || sn == 0 || ss == 0) begin
                e.value  = p.v[CORNER_NW];
                e.corner = CORNER_NW;
                e.zero   = 1'b1;
            end else begin
                w1 = frac_div(longint'(p.nlat) - longint'(p.tlat), span);
                if (w1 < -one) w1 = -one;
                if (w1 > 2 * one) w1 = 2 * one;
                w2   = one - w1;
                fwn  = row_frac(p.tlon, sn);
                fws  = row_frac(p.tlon, ss);
                d[0] = fwn * fwn + w1 * w1;
                d[1] = (one - fwn) * (one - fwn) + w1 * w1;
                d[2] = fws * fws + w2 * w2;
                d[3] = (one - fws) * (one - fws) + w2 * w2;
                if (ahead(d[0], d[1]) && ahead(d[0], d[2]) && ahead(d[0], d[3]))
                    e.corner = CORNER_NW;
                else if (ahead(d[1], d[2]) && ahead(d[1], d[3]))
                    e.corner = CORNER_NE;
                else if (ahead(d[2], d[3]))
                    e.corner = CORNER_SW;
                else
                    e.corner = CORNER_SE;
                e.value = p.v[e.corner];
                e.zero  = 1'b0;
            end
            owed.push_back(e);
        endfunction

        function void check_pick(logic [VAL_W-1:0] value, logic [1:0] corner,
                                 logic zero);
            t_pick e;
            if (owed.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (value !== e.value) begin
                $error("chosen_value expected %h actual %h", e.value, value);
                errors++;
            end
            if (corner !== e.corner) begin
                $error("chosen_corner expected %0d actual %0d", e.corner, corner);
                errors++;
            end
            if (zero !== e.zero) begin
                $error("zero_divisor expected %0d actual %0d", e.zero, zero);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = NB + 5;
    localparam int LAT_MAX = 90000000;
    localparam int LON_MIN = -360000000;
    localparam int LON_MAX = 720000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [TOL_W-1:0] i_cfg_wdata;

    gncs_in_if  in_ch ();
    gncs_out_if res_ch ();

    grid_nearest_corner_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_res       (res_ch.source)
    );

    corner_board board = new();

    // Idle rates in percent; the stimulus process changes them per phase.
    int send_idle_pct;
    int take_idle_pct;
    // When nonzero the receiver holds ready low for this many cycles.
    int hold_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Results are sampled at the edge where the handshake completes; ready is
    // then redrawn for the next cycle by a single nonblocking assignment.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                board.check_pick(res_ch.chosen_value, res_ch.chosen_corner,
                                 res_ch.zero_divisor);
            if (hold_cycles > 0) begin
                hold_cycles  <= hold_cycles - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
            end
        end
    end

    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Offers one item and returns once it has been accepted. Random idle
    // cycles are inserted before the item according to the current rate.
    task automatic send_point(t_point p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.target_lat    <= p.tlat;
        in_ch.target_lon    <= p.tlon;
        in_ch.north_row_lat <= p.nlat;
        in_ch.south_row_lat <= p.slat;
        in_ch.nw_lon        <= p.lnw;
        in_ch.ne_lon        <= p.lne;
        in_ch.sw_lon        <= p.lsw;
        in_ch.se_lon        <= p.lse;
        in_ch.nw_value      <= p.v[0];
        in_ch.ne_value      <= p.v[1];
        in_ch.sw_value      <= p.v[2];
        in_ch.se_value      <= p.v[3];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_point(p);
    endtask

    // Lowers valid after the last item of a burst.
    task automatic end_burst();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every pick has arrived, then lets the pipeline run dry
    // before the tolerance changes.
    task automatic drain_and_set(logic [TOL_W-1:0] tol);
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= tol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.tol    = tol;
    endtask

    function automatic t_point random_values(t_point p);
        foreach (p.v[k]) p.v[k] = {$urandom, $urandom};
        return p;
    endfunction

    // A cell item: the target latitude mostly lies near the cell, and the corners
    // are mostly one grid spacing apart. Spacings are mostly small so fractions vary.
    function automatic t_point cell_point();
        t_point p;
        int     dlat, dlon, base;
        dlat   = ($urandom_range(3) == 0) ? rnd_in(1, 5000000) : rnd_in(1, 2000);
        dlon   = ($urandom_range(3) == 0) ? rnd_in(1, 5000000) : rnd_in(1, 2000);
        p.slat = rnd_in(-LAT_MAX, LAT_MAX - dlat);
        p.nlat = p.slat + dlat;
        if ($urandom_range(5) == 0) begin
            p.nlat = p.slat;
            p.slat = p.slat + dlat;
        end
        p.tlat = rnd_in(-LAT_MAX, LAT_MAX);
        if ($urandom_range(3) != 0)
            p.tlat = p.slat + rnd_in(-dlat, 2 * dlat) / 1;
        if (p.tlat > LAT_MAX) p.tlat = LAT_MAX;
        if (p.tlat < -LAT_MAX) p.tlat = -LAT_MAX;
        p.tlon = rnd_in(LON_MIN, LON_MAX);
        base   = rnd_in(LON_MIN, LON_MAX - 2 * dlon);
        p.lnw  = base;
        p.lne  = base + dlon;
        p.lsw  = base;
        p.lse  = base + ($urandom_range(1) ? dlon : rnd_in(1, dlon));
        if ($urandom_range(9) == 0) p.lse = p.lsw;
        if ($urandom_range(9) == 0) p.lne = p.lnw - dlon;
        return random_values(p);
    endfunction

    // Unstructured item anywhere in the legal ranges.
    function automatic t_point noise_point();
        t_point p;
        p.tlat = rnd_in(-LAT_MAX, LAT_MAX);
        p.nlat = rnd_in(-LAT_MAX, LAT_MAX);
        p.slat = rnd_in(-LAT_MAX, LAT_MAX);
        p.tlon = rnd_in(LON_MIN, LON_MAX);
        p.lnw  = rnd_in(LON_MIN, LON_MAX);
        p.lne  = rnd_in(LON_MIN, LON_MAX);
        p.lsw  = rnd_in(LON_MIN, LON_MAX);
        p.lse  = rnd_in(LON_MIN, LON_MAX);
        return random_values(p);
    endfunction

    // Directed corners: range extremes, saturation of the weight at its upper
    // bound, exact ties, zero span and zero row spacings.
    task automatic directed_part();
        t_point p;
        p = cell_point();
        p.tlat = -LAT_MAX; p.nlat = LAT_MAX; p.slat = LAT_MAX - 1;
        p.tlon = LON_MIN; p.lnw = LON_MIN; p.lne = LON_MAX;
        p.lsw = LON_MAX; p.lse = LON_MIN;
        send_point(p);
        p.tlat = LAT_MAX; p.nlat = -LAT_MAX; p.slat = -LAT_MAX + 1;
        p.tlon = LON_MAX;
        send_point(p);
        p.v = '{'1, '0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        p.tlat = 0; p.nlat = 1000; p.slat = -1000;
        p.tlon = 0; p.lnw = 0; p.lne = 1000; p.lsw = 0; p.lse = 1000;
        send_point(p);  // target on the middle row line, on a corner column
        p.tlon = 500;
        send_point(p);  // four-way tie
        p.nlat = p.slat;
        send_point(p);  // zero latitude span
        p.nlat = 1000; p.lne = p.lnw;
        send_point(p);  // zero northern spacing
        p.lne = 1000; p.lse = p.lsw;
        send_point(p);  // zero southern spacing
        p.lse = 1000; p.tlon = -1500; p.tlat = 1000;
        send_point(p);  // negative quotient, north row
        p.tlat = -1000; p.tlon = 1750;
        send_point(p);
        p.tlat = 3000;
        send_point(p);
        repeat (12) send_point(cell_point());
        repeat (3) send_point(noise_point());
        end_burst();
    endtask

    task automatic random_part(int count);
        repeat (count) begin
            if ($urandom_range(9) < 8)
                send_point(cell_point());
            else
                send_point(noise_point());
        end
        end_burst();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.target_lat = '0;
        in_ch.target_lon = '0;
        in_ch.north_row_lat = '0;
        in_ch.south_row_lat = '0;
        in_ch.nw_lon = '0;
        in_ch.ne_lon = '0;
        in_ch.sw_lon = '0;
        in_ch.se_lon = '0;
        in_ch.nw_value = '0;
        in_ch.ne_value = '0;
        in_ch.sw_value = '0;
        in_ch.se_value = '0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        hold_cycles   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset tolerance is checked first, then the extremes.
        directed_part();
        drain_and_set('0);
        directed_part();
        drain_and_set('1);
        directed_part();

        // Phase one: sender idles often, receiver idles more.
        drain_and_set(TOL_W'(1));
        send_idle_pct = 38;
        take_idle_pct = 66;
        random_part(300);

        // Phase two: the other way round, with a long receiver hold-off so
        // the pipeline fills and pushes back on the sender.
        drain_and_set(TOL_W'($urandom_range(2000)));
        send_idle_pct = 66;
        take_idle_pct = 38;
        hold_cycles   = 4 * LATENCY;
        random_part(300);

        // Phase three: full rate on both sides.
        drain_and_set(TOL_W'($urandom));
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_part(330);

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.errors == 0)
            $display("grid_nearest_corner_select: match");
        else
            $display("grid_nearest_corner_select: mismatch");
        $finish;
    end

    // Watchdog well beyond the slowest legitimate run.
    initial begin
        #20ms;
        $display("grid_nearest_corner_select: mismatch");
        $finish;
    end

endmodule
